// ----- design/lstg_pkg.sv -----
package lstg_pkg;

    localparam int IDX_W     = 18;
    localparam int ROW_W     = 21;
    localparam int VAL_W     = 34;
    localparam int BASIS_W   = 31;
    localparam int SIDE_W    = 7;
    localparam int POS_W     = 6;
    localparam int SQ_W      = 13;
    localparam int MAX_SIDE  = 64;
    localparam int DOFS      = 6;
    localparam int DIRS      = 6;
    localparam int COUP_N    = 9;
    localparam int STEP_BITS = 3;
    localparam int DIV_ST    = IDX_W / STEP_BITS;
    localparam int NST       = 2 * DIV_ST;
    localparam int IN_BYTES_W  = 24;
    localparam int OUT_BYTES_W = 80;

    typedef enum logic [1:0] {
        REG_SIDE = 2'd0,
        REG_K    = 2'd1,
        REG_KR   = 2'd2,
        REG_KR2  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        BASIS_K   = 2'd0,
        BASIS_KR  = 2'd1,
        BASIS_KR2 = 2'd2
    } basis_t;

    typedef enum logic [2:0] {
        M_NEG1  = 3'd0,
        M_ONE   = 3'd1,
        M_TWO   = 3'd2,
        M_THREE = 3'd3,
        M_FOUR  = 3'd4
    } mult_t;

    typedef struct packed {
        logic [2:0] rdof;
        logic [2:0] cdof;
        basis_t     basis;
        mult_t      mult;
    } coup_t;

    localparam mult_t DIAG_TAB [4][DOFS] = '{
        '{M_TWO, M_TWO, M_TWO, M_FOUR, M_FOUR, M_FOUR},
        '{M_TWO, M_TWO, M_TWO, M_FOUR, M_THREE, M_THREE},
        '{M_ONE, M_ONE, M_TWO, M_THREE, M_THREE, M_TWO},
        '{M_ONE, M_ONE, M_ONE, M_TWO, M_TWO, M_TWO}
    };

    localparam coup_t COUP_TAB [DIRS][COUP_N] = '{
        '{'{3'd0, 3'd0, BASIS_K, M_NEG1}, '{3'd1, 3'd1, BASIS_K, M_NEG1},
          '{3'd2, 3'd2, BASIS_K, M_NEG1}, '{3'd4, 3'd4, BASIS_KR2, M_NEG1},
          '{3'd5, 3'd5, BASIS_KR2, M_NEG1}, '{3'd1, 3'd5, BASIS_KR, M_ONE},
          '{3'd2, 3'd4, BASIS_KR, M_NEG1}, '{3'd4, 3'd2, BASIS_KR, M_NEG1},
          '{3'd5, 3'd1, BASIS_KR, M_ONE}},
        '{'{3'd0, 3'd0, BASIS_K, M_NEG1}, '{3'd1, 3'd1, BASIS_K, M_NEG1},
          '{3'd2, 3'd2, BASIS_K, M_NEG1}, '{3'd4, 3'd4, BASIS_KR2, M_NEG1},
          '{3'd5, 3'd5, BASIS_KR2, M_NEG1}, '{3'd1, 3'd5, BASIS_KR, M_NEG1},
          '{3'd2, 3'd4, BASIS_KR, M_ONE}, '{3'd4, 3'd2, BASIS_KR, M_ONE},
          '{3'd5, 3'd1, BASIS_KR, M_NEG1}},
        '{'{3'd0, 3'd0, BASIS_K, M_NEG1}, '{3'd1, 3'd1, BASIS_K, M_NEG1},
          '{3'd2, 3'd2, BASIS_K, M_NEG1}, '{3'd3, 3'd3, BASIS_KR2, M_NEG1},
          '{3'd5, 3'd5, BASIS_KR2, M_NEG1}, '{3'd0, 3'd5, BASIS_KR, M_NEG1},
          '{3'd2, 3'd3, BASIS_KR, M_ONE}, '{3'd5, 3'd0, BASIS_KR, M_NEG1},
          '{3'd3, 3'd2, BASIS_KR, M_ONE}},
        '{'{3'd0, 3'd0, BASIS_K, M_NEG1}, '{3'd1, 3'd1, BASIS_K, M_NEG1},
          '{3'd2, 3'd2, BASIS_K, M_NEG1}, '{3'd3, 3'd3, BASIS_KR2, M_NEG1},
          '{3'd5, 3'd5, BASIS_KR2, M_NEG1}, '{3'd2, 3'd3, BASIS_KR, M_NEG1},
          '{3'd5, 3'd0, BASIS_KR, M_ONE}, '{3'd0, 3'd5, BASIS_KR, M_ONE},
          '{3'd3, 3'd2, BASIS_KR, M_NEG1}},
        '{'{3'd0, 3'd0, BASIS_K, M_NEG1}, '{3'd1, 3'd1, BASIS_K, M_NEG1},
          '{3'd2, 3'd2, BASIS_K, M_NEG1}, '{3'd3, 3'd3, BASIS_KR2, M_NEG1},
          '{3'd4, 3'd4, BASIS_KR2, M_NEG1}, '{3'd1, 3'd3, BASIS_KR, M_NEG1},
          '{3'd0, 3'd4, BASIS_KR, M_ONE}, '{3'd3, 3'd1, BASIS_KR, M_NEG1},
          '{3'd4, 3'd0, BASIS_KR, M_ONE}},
        '{'{3'd0, 3'd0, BASIS_K, M_NEG1}, '{3'd1, 3'd1, BASIS_K, M_NEG1},
          '{3'd2, 3'd2, BASIS_K, M_NEG1}, '{3'd3, 3'd3, BASIS_KR2, M_NEG1},
          '{3'd4, 3'd4, BASIS_KR2, M_NEG1}, '{3'd0, 3'd4, BASIS_KR, M_NEG1},
          '{3'd1, 3'd3, BASIS_KR, M_ONE}, '{3'd3, 3'd1, BASIS_KR, M_ONE},
          '{3'd4, 3'd0, BASIS_KR, M_NEG1}}
    };

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [IDX_W-1:0]  num;
        logic [IDX_W-1:0]  quo;
        logic [SIDE_W-1:0] rem;
        logic [POS_W-1:0]  x;
    } st_t;

endpackage

// ----- design/lattice_stiffness_triplet_generator_unit.sv -----
// Lattice stiffness triplet generator.
// The input channel (s_tvalid, s_tready, s_tdata) carries one element index per
// transfer. The result channel (m_tvalid, m_tready, m_tdata, m_tlast) carries
// one stiffness entry per transfer, and m_tlast marks the final entry of an
// element. An element inside the lattice yields 6 diagonal entries and then 9
// entries for each neighbor inside the lattice, so 6 to 60 transfers; an index
// whose low 18 bits are at or beyond side_count cubed yields none.
// Coordinates come from a 12-stage divider pipeline, three quotient bits per
// stage, that divides the index by the side count twice. The entry sequencer
// sends one entry per cycle while the receiver accepts them, and following
// elements fill the divider pipeline behind the element being sent.
// The configuration port writes side_count, k, k*r and k*r^2 by index. The
// user must write it only while the block is idle; the block does not enforce it.
// Reset clears all valid bits and restores the register defaults. When the
// receiver stalls, the output register holds its entry, the sequencer stops,
// and the pipeline stops with s_tready low once its last stage waits to load.
module lattice_stiffness_triplet_generator_unit
    import lstg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // element_index
    input  logic [IN_BYTES_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // row_index, col_index, entry_value
    output logic [OUT_BYTES_W-1:0] m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [BASIS_W-1:0]     cfg_wdata
);

    logic [SIDE_W-1:0]  side_reg;
    logic [BASIS_W-1:0] k_reg, kr_reg, kr2_reg;

    logic [SIDE_W-1:0] n_eff, n_m1;
    logic [SQ_W-1:0]   n_sq;

    st_t  st_reg  [NST+1];
    st_t  st_next [NST+1];
    logic st_v_reg [NST+1];
    logic en;

    logic              busy_reg, diag_reg;
    logic [3:0]        slot_reg;
    logic [2:0]        dir_reg;
    logic [IDX_W-1:0]  eidx_reg;
    logic [1:0]        faces_reg;
    logic [DIRS-1:0]   inside_reg;

    logic              m_tvalid_reg, m_tlast_reg;
    logic [ROW_W-1:0]  row_reg, col_reg;
    logic [VAL_W-1:0]  val_reg;

    logic [IDX_W-1:0]  t_z;
    logic [POS_W-1:0]  t_x, t_y;
    logic              t_in, load, step, out_free, is_last;
    logic [1:0]        t_faces;
    logic [DIRS-1:0]   t_inside, rem_mask;
    logic [2:0]        first_dir;

    logic [2:0]        rdof, cdof;
    basis_t            basis;
    mult_t             mult;
    logic [IDX_W-1:0]  pidx;
    logic [ROW_W-1:0]  row_next, col_next;
    logic [VAL_W-1:0]  val_next, bext;
    logic [BASIS_W-1:0] bsel;
    coup_t             ce;

    always_comb begin
        if (side_reg == '0) begin
            n_eff = SIDE_W'(1);
        end else if (side_reg > SIDE_W'(MAX_SIDE)) begin
            n_eff = SIDE_W'(MAX_SIDE);
        end else begin
            n_eff = side_reg;
        end
        n_m1 = n_eff - SIDE_W'(1);
        n_sq = SQ_W'(n_eff) * SQ_W'(n_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= SIDE_W'(2);
            k_reg    <= '0;
            kr_reg   <= '0;
            kr2_reg  <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_SIDE: side_reg <= cfg_wdata[SIDE_W-1:0];
                REG_K:    k_reg    <= cfg_wdata;
                REG_KR:   kr_reg   <= cfg_wdata;
                REG_KR2:  kr2_reg  <= cfg_wdata;
                default:  ;
            endcase
        end
    end

    // Divider pipeline: each stage retires three restoring-division steps.
    always_comb begin
        st_t              t;
        logic [SIDE_W:0]  r;
        logic             qb;
        st_next[0] = st_reg[0];
        for (int s = 0; s < NST; s++) begin
            t = st_reg[s];
            for (int b = 0; b < STEP_BITS; b++) begin
                r  = {t.rem, t.num[IDX_W-1]};
                qb = (r >= {1'b0, n_eff});
                if (qb) begin
                    r = r - {1'b0, n_eff};
                end
                t.rem = r[SIDE_W-1:0];
                t.num = {t.num[IDX_W-2:0], 1'b0};
                t.quo = {t.quo[IDX_W-2:0], qb};
            end
            if (s == DIV_ST - 1) begin
                t.x   = t.rem[POS_W-1:0];
                t.num = t.quo;
                t.quo = '0;
                t.rem = '0;
            end
            st_next[s+1] = t;
        end
    end

    assign t_z  = st_reg[NST].quo;
    assign t_y  = st_reg[NST].rem[POS_W-1:0];
    assign t_x  = st_reg[NST].x;
    assign t_in = (t_z < IDX_W'(n_eff));

    always_comb begin
        logic fx, fy, fz;
        fx = (t_x == '0) || (SIDE_W'(t_x) == n_m1);
        fy = (t_y == '0) || (SIDE_W'(t_y) == n_m1);
        fz = (t_z[POS_W-1:0] == '0) || (SIDE_W'(t_z[POS_W-1:0]) == n_m1);
        t_faces  = 2'(fx) + 2'(fy) + 2'(fz);
        t_inside = {t_z[POS_W-1:0] != '0, SIDE_W'(t_z[POS_W-1:0]) < n_m1,
                    t_y != '0, SIDE_W'(t_y) < n_m1,
                    t_x != '0, SIDE_W'(t_x) < n_m1};
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign step     = busy_reg && out_free;
    assign load     = st_v_reg[NST] && t_in && (!busy_reg || (step && is_last));
    assign en       = !st_v_reg[NST] || !t_in || load;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NST; s++) begin
                st_v_reg[s] <= 1'b0;
            end
        end else if (en) begin
            st_v_reg[0] <= s_tvalid;
            for (int s = 0; s < NST; s++) begin
                st_v_reg[s+1] <= st_v_reg[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].idx <= s_tdata[IDX_W-1:0];
            st_reg[0].num <= s_tdata[IDX_W-1:0];
            st_reg[0].quo <= '0;
            st_reg[0].rem <= '0;
            st_reg[0].x   <= '0;
            for (int s = 1; s <= NST; s++) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    // Entry sequencer.
    always_comb begin
        logic [DIRS-1:0] above;
        above = '1;
        if (!diag_reg) begin
            above = ~((DIRS'(2) << dir_reg) - DIRS'(1));
        end
        rem_mask  = inside_reg & above;
        first_dir = '0;
        for (int d = DIRS - 1; d >= 0; d--) begin
            if (rem_mask[d]) begin
                first_dir = 3'(d);
            end
        end
        is_last = (diag_reg ? (slot_reg == 4'(DOFS - 1))
                            : (slot_reg == 4'(COUP_N - 1))) && (rem_mask == '0);
    end

    always_comb begin
        ce = COUP_TAB[dir_reg][slot_reg];
        if (diag_reg) begin
            rdof  = slot_reg[2:0];
            cdof  = slot_reg[2:0];
            mult  = DIAG_TAB[faces_reg][slot_reg[2:0]];
            basis = (slot_reg < 4'd3) ? BASIS_K : BASIS_KR2;
            pidx  = eidx_reg;
        end else begin
            rdof  = ce.rdof;
            cdof  = ce.cdof;
            mult  = ce.mult;
            basis = ce.basis;
            case (dir_reg)
                3'd0:    pidx = eidx_reg + IDX_W'(1);
                3'd1:    pidx = eidx_reg - IDX_W'(1);
                3'd2:    pidx = eidx_reg + IDX_W'(n_eff);
                3'd3:    pidx = eidx_reg - IDX_W'(n_eff);
                3'd4:    pidx = eidx_reg + IDX_W'(n_sq);
                default: pidx = eidx_reg - IDX_W'(n_sq);
            endcase
        end
        case (basis)
            BASIS_K:  bsel = k_reg;
            BASIS_KR: bsel = kr_reg;
            default:  bsel = kr2_reg;
        endcase
        bext = VAL_W'(bsel);
        case (mult)
            M_NEG1:  val_next = -bext;
            M_ONE:   val_next = bext;
            M_TWO:   val_next = bext << 1;
            M_THREE: val_next = bext + (bext << 1);
            default: val_next = bext << 2;
        endcase
        row_next = (ROW_W'(eidx_reg) << 2) + (ROW_W'(eidx_reg) << 1) + ROW_W'(rdof);
        col_next = (ROW_W'(pidx) << 2) + (ROW_W'(pidx) << 1) + ROW_W'(cdof);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            diag_reg     <= 1'b1;
            slot_reg     <= '0;
            dir_reg      <= '0;
        end else begin
            if (step) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (load) begin
                busy_reg <= 1'b1;
                diag_reg <= 1'b1;
                slot_reg <= '0;
                dir_reg  <= '0;
            end else if (step) begin
                if (is_last) begin
                    busy_reg <= 1'b0;
                end else if (diag_reg ? (slot_reg == 4'(DOFS - 1))
                                      : (slot_reg == 4'(COUP_N - 1))) begin
                    diag_reg <= 1'b0;
                    slot_reg <= '0;
                    dir_reg  <= first_dir;
                end else begin
                    slot_reg <= slot_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            eidx_reg   <= st_reg[NST].idx;
            faces_reg  <= t_faces;
            inside_reg <= t_inside;
        end
        if (step) begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            val_reg     <= val_next;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {(OUT_BYTES_W - 2 * ROW_W - VAL_W)'(0), val_reg, col_reg, row_reg};

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && busy_reg) |-> (step && is_last))
        else $error("new element loaded while the sequencer is still busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && is_last && !load) |=> !busy_reg)
        else $error("sequencer stays busy after the final entry");

    a_dir_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !diag_reg) |-> inside_reg[dir_reg])
        else $error("coupling entry for a neighbor outside the lattice");

endmodule
